// File: hdl/rwz_pkg.sv
package rwz_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int Z_BITS      = 24;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_BITS    = 11;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd20;

  // Root search width and the quotient that feeds it (root of a QUOT_BITS value)
  localparam int ROOT_BITS = Z_BITS;
  localparam int QUOT_BITS = 2 * ROOT_BITS;
  // Dividend is |num|^2 << 2*FRAC_BITS; the divider starts from |num|^2 >> DIV_SHIFT
  localparam int DIV_SHIFT = QUOT_BITS - 2 * FRAC_BITS;

  localparam logic [ROOT_BITS-1:0] K_POS_LIM = ROOT_BITS'((1 << (Z_BITS - 1)) - 1);
  localparam logic [ROOT_BITS-1:0] K_NEG_LIM = ROOT_BITS'(1 << (Z_BITS - 1));
  localparam logic [Z_BITS-1:0]    Z_MAX     = Z_BITS'((1 << (Z_BITS - 1)) - 1);
  localparam logic [Z_BITS-1:0]    Z_MIN     = Z_BITS'(1 << (Z_BITS - 1));

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } calc_op_e;

  typedef struct packed {
    logic     start;
    calc_op_e op;
  } calc_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } calc_stat_t;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic signed [Z_BITS-1:0] zscore;
    logic                     window_full;
  } result_req_t;

endpackage

// File: hdl/rwz_calc.sv
module rwz_calc #(
  parameter int unsigned PROD_BITS = 70
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rwz_pkg::calc_ctrl_t           ctrl_i,
  input  logic [PROD_BITS-1:0]          opa_i,
  input  logic [rwz_pkg::QUOT_BITS-1:0] opb_i,
  output rwz_pkg::calc_stat_t           stat_o,
  output logic [PROD_BITS-1:0]          acc_o,
  output logic [rwz_pkg::QUOT_BITS-1:0] res_o
);
  import rwz_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_DCHK = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;

  localparam int CNT_W = $clog2(QUOT_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUOT_BITS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_BITS - 1);

  logic [2:0]           state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q, ovf_q;
  logic [PROD_BITS-1:0] acc_q, opa_q;
  logic [QUOT_BITS-1:0] opb_q, res_q;

  logic [PROD_BITS-1:0] add_x, add_y;
  logic                 add_sub;
  logic [PROD_BITS:0]   sum;
  logic                 carry;

  // the one shared adder/subtractor; carry out on subtract means x >= y
  always_comb begin
    add_x   = acc_q;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      U_MUL: begin
        add_y = opb_q[0] ? opa_q : '0;
      end
      U_DCHK: begin
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      U_DIV: begin
        add_x   = {acc_q[PROD_BITS-2:0], opb_q[QUOT_BITS-1]};
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      U_SQRT: begin
        add_x   = {acc_q[PROD_BITS-3:0], opb_q[QUOT_BITS-1 -: 2]};
        add_y   = PROD_BITS'({res_q[ROOT_BITS-1:0], 2'b01});
        add_sub = 1'b1;
      end
      default: begin
        add_y = '0;
      end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y ^ {PROD_BITS{add_sub}}}
               + {{PROD_BITS{1'b0}}, add_sub};
  assign carry = sum[PROD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        U_IDLE: begin
          if (ctrl_i.start) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
            case (ctrl_i.op)
              OP_MUL:  state_q <= U_MUL;
              OP_DIV:  state_q <= U_DCHK;
              OP_SQRT: state_q <= U_SQRT;
              default: state_q <= U_IDLE;
            endcase
          end
        end
        U_MUL: begin
          if (opb_q == '0) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end
        end
        U_DCHK: begin
          // quotient would not fit: saturate
          if (carry) begin
            ovf_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end else begin
            state_q <= U_DIV;
          end
        end
        U_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == DIV_LAST) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end
        end
        U_SQRT: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == SQRT_LAST) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && state_q == U_IDLE) begin
      case (ctrl_i.op)
        OP_MUL: begin
          acc_q <= '0;
          opa_q <= opa_i;
          opb_q <= opb_i;
        end
        OP_DIV: begin
          // dividend is the product left in acc by the preceding multiply
          acc_q <= acc_q >> DIV_SHIFT;
          opa_q <= opa_i;
          opb_q <= {acc_q[DIV_SHIFT-1:0], {(QUOT_BITS - DIV_SHIFT){1'b0}}};
          res_q <= '0;
        end
        OP_SQRT: begin
          // radicand is the quotient left in res by the preceding divide
          acc_q <= '0;
          opb_q <= res_q;
          res_q <= '0;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end else begin
      case (state_q)
        U_MUL: begin
          acc_q <= sum[PROD_BITS-1:0];
          opa_q <= opa_q << 1;
          opb_q <= opb_q >> 1;
        end
        U_DIV: begin
          acc_q <= carry ? sum[PROD_BITS-1:0] : add_x;
          res_q <= {res_q[QUOT_BITS-2:0], carry};
          opb_q <= opb_q << 1;
        end
        U_SQRT: begin
          acc_q <= carry ? sum[PROD_BITS-1:0] : add_x;
          res_q <= {res_q[QUOT_BITS-2:0], carry};
          opb_q <= opb_q << 2;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign stat_o = '{done: done_q, ovf: ovf_q};
  assign acc_o  = acc_q;
  assign res_o  = res_q;

endmodule

// File: hdl/rolling_window_zscore.sv
// Rolling z-score over the last window_length samples (0 counts as 1, values above
// WINDOW_MAX are clamped). Each sample request returns one result: zscore is
// (n*x - S) / sqrt(n*Q - S^2) in signed Q7.16, truncated toward zero and saturated,
// where n, S and Q are the count, sum and sum of squares of the held samples after
// this one enters; it is 0 while fewer than two samples are held or the spread is
// zero. A clear request, or any write of window_length, empties the window. The
// input is stalled while a request is in progress and during a register write. A
// sample first passes the window update (S_OLD, S_SUM, S_NX), then one shared
// add/subtract unit runs three shift-add multiplies (one multiplier bit per cycle,
// ending early once the remaining bits are zero), a 48-step restoring divide and a
// 24-step square root. A clear, or a sample with fewer than two held, skips the
// arithmetic. The result then waits in an output register until taken.
module rolling_window_zscore #(
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rwz_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rwz_pkg::sample_req_t         in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rwz_pkg::result_req_t         out_req_o
);
  import rwz_pkg::*;

  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int PTRW  = $clog2(WINDOW_MAX);
  localparam int SB    = SAMPLE_BITS;
  localparam int SW    = SB + CW + 1;
  localparam int MAGW  = SB + CW;
  localparam int QW    = 2 * SB - 1 + CW;
  localparam int PW    = 2 * MAGW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OLD  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_NX   = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_MNQ  = 4'd5;
  localparam logic [3:0] S_MSS  = 4'd6;
  localparam logic [3:0] S_MMG  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]             state_q;
  logic [CFG_BITS-1:0]    wl_q;
  logic [CW-1:0]          fill_q, len;
  logic [PTRW-1:0]        wp_q;
  logic signed [SW-1:0]   s_q;
  logic [QW-1:0]          q_q;

  logic signed [SB-1:0]   x_q, rd_q;
  logic [2*SB-1:0]        xsq_q, old_sq_q;
  logic signed [SW-1:0]   nx_q;
  logic                   neg_q;
  logic [MAGW-1:0]        mag_q;
  logic [PW-1:0]          dv_q;
  logic [Z_BITS-1:0]      z_q;
  logic                   full_q;
  logic                   out_valid_q;
  result_req_t            out_req_q;

  logic signed [SB-1:0]   ring_mem [WINDOW_MAX];

  logic                   in_acc, out_free, grow;
  logic [CW-1:0]          wp_nxt;
  logic signed [SW-1:0]   num;
  logic [SW-1:0]          num_abs, s_abs;
  logic [MAGW-1:0]        smag;
  logic [Z_BITS-1:0]      z_calc;
  logic [ROOT_BITS-1:0]   k;

  calc_ctrl_t             calc_ctrl;
  calc_stat_t             calc_stat;
  logic [PW-1:0]          calc_opa, calc_acc;
  logic [QUOT_BITS-1:0]   calc_opb, calc_res;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_we_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  always_comb begin
    if (wl_q == '0) begin
      len = CW'(1);
    end else if (32'(wl_q) > WINDOW_MAX) begin
      len = CW'(WINDOW_MAX);
    end else begin
      len = CW'(wl_q);
    end
  end

  assign grow   = fill_q < len;
  assign wp_nxt = CW'(wp_q) + CW'(1);

  assign num     = nx_q - s_q;
  assign num_abs = num[SW-1] ? SW'(-num) : SW'(num);
  assign s_abs   = s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
  assign smag    = s_abs[MAGW-1:0];

  assign k = calc_res[ROOT_BITS-1:0];

  always_comb begin
    if (calc_stat.ovf) begin
      z_calc = neg_q ? Z_MIN : Z_MAX;
    end else if (!neg_q) begin
      z_calc = (k > K_POS_LIM) ? Z_MAX : Z_BITS'(k);
    end else begin
      z_calc = (k > K_NEG_LIM) ? Z_MIN : Z_BITS'(ROOT_BITS'(0) - k);
    end
  end

  always_comb begin
    calc_ctrl = '{start: 1'b0, op: OP_MUL};
    calc_opa  = '0;
    calc_opb  = '0;
    case (state_q)
      S_NUM: begin
        calc_ctrl = '{start: 1'b1, op: OP_MUL};
        calc_opa  = PW'(q_q);
        calc_opb  = QUOT_BITS'(fill_q);
      end
      S_MNQ: begin
        if (calc_stat.done) begin
          calc_ctrl = '{start: 1'b1, op: OP_MUL};
          calc_opa  = PW'(smag);
          calc_opb  = QUOT_BITS'(smag);
        end
      end
      S_MSS: begin
        if (calc_stat.done && dv_q > calc_acc) begin
          calc_ctrl = '{start: 1'b1, op: OP_MUL};
          calc_opa  = PW'(mag_q);
          calc_opb  = QUOT_BITS'(mag_q);
        end
      end
      S_MMG: begin
        if (calc_stat.done) begin
          calc_ctrl = '{start: 1'b1, op: OP_DIV};
          calc_opa  = dv_q;
        end
      end
      S_DIV: begin
        if (calc_stat.done && !calc_stat.ovf) begin
          calc_ctrl = '{start: 1'b1, op: OP_SQRT};
        end
      end
      default: begin
        calc_opa = '0;
      end
    endcase
  end

  rwz_calc #(
    .PROD_BITS(PW)
  ) u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (calc_ctrl),
    .opa_i  (calc_opa),
    .opb_i  (calc_opb),
    .stat_o (calc_stat),
    .acc_o  (calc_acc),
    .res_o  (calc_res)
  );

  // sequencer and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      wl_q        <= CFG_RESET;
      fill_q      <= '0;
      wp_q        <= '0;
      s_q         <= '0;
      q_q         <= '0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        wl_q   <= cfg_wdata_i;
        fill_q <= '0;
        wp_q   <= '0;
        s_q    <= '0;
        q_q    <= '0;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_acc) begin
              if (in_req_i.kind) begin
                fill_q  <= '0;
                wp_q    <= '0;
                s_q     <= '0;
                q_q     <= '0;
                state_q <= S_DONE;
              end else begin
                state_q <= S_OLD;
              end
            end
          end
          S_OLD: begin
            s_q     <= s_q + SW'(x_q);
            q_q     <= q_q + QW'(xsq_q);
            state_q <= S_SUM;
          end
          S_SUM: begin
            // window full: the oldest sample leaves
            if (grow) begin
              fill_q <= fill_q + CW'(1);
            end else begin
              s_q <= s_q - SW'(rd_q);
              q_q <= q_q - QW'(old_sq_q);
            end
            wp_q    <= (wp_nxt >= len) ? '0 : wp_nxt[PTRW-1:0];
            state_q <= S_NX;
          end
          S_NX: begin
            state_q <= (fill_q < CW'(2)) ? S_DONE : S_NUM;
          end
          S_NUM: begin
            state_q <= S_MNQ;
          end
          S_MNQ: begin
            if (calc_stat.done) begin
              state_q <= S_MSS;
            end
          end
          S_MSS: begin
            if (calc_stat.done) begin
              state_q <= (dv_q > calc_acc) ? S_MMG : S_DONE;
            end
          end
          S_MMG: begin
            if (calc_stat.done) begin
              state_q <= S_DIV;
            end
          end
          S_DIV: begin
            if (calc_stat.done) begin
              state_q <= calc_stat.ovf ? S_DONE : S_SQRT;
            end
          end
          S_SQRT: begin
            if (calc_stat.done) begin
              state_q <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q    <= in_req_i.sample;
          xsq_q  <= $signed(in_req_i.sample) * $signed(in_req_i.sample);
          z_q    <= '0;
          full_q <= 1'b0;
        end
      end
      S_OLD: begin
        old_sq_q <= rd_q * rd_q;
      end
      S_NX: begin
        full_q <= (fill_q == len);
        nx_q   <= $signed({1'b0, fill_q}) * x_q;
      end
      S_NUM: begin
        neg_q <= num[SW-1];
        mag_q <= num_abs[MAGW-1:0];
      end
      S_MNQ: begin
        if (calc_stat.done) begin
          dv_q <= calc_acc;
        end
      end
      S_MSS: begin
        // n*Q - S^2; zero spread leaves z at 0
        if (calc_stat.done) begin
          dv_q <= dv_q - calc_acc;
        end
      end
      S_DIV: begin
        if (calc_stat.done && calc_stat.ovf) begin
          z_q <= z_calc;
        end
      end
      S_SQRT: begin
        if (calc_stat.done) begin
          z_q <= z_calc;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_req_q.zscore      <= z_q;
          out_req_q.window_full <= full_q;
        end
      end
      default: begin
        z_q <= z_q;
      end
    endcase
  end

  // ring of samples: read the slot about to be overwritten, write the new sample
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= ring_mem[wp_q];
    end
    if (state_q == S_OLD) begin
      ring_mem[wp_q] <= x_q;
    end
  end

endmodule
